### rtl/bog_pkg.sv
package bog_pkg;

  localparam int LIMIT_W  = 17;
  localparam int OFFSET_W = 16;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  localparam logic CMD_NEXT    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic REG_INDEX_LIMIT = 1'b0;

  function automatic logic [LIMIT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] raw,
                                                   input logic [LIMIT_W-1:0] top);
    logic [LIMIT_W-1:0] lim;
    lim = (raw == '0) ? LIMIT_W'(1) : raw;
    if (lim > top) begin
      lim = top;
    end
    return lim;
  endfunction

  function automatic logic [COUNT_W-1:0] bits_for(input logic [LIMIT_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < LIMIT_W; i++) begin
      if (v[i]) begin
        n = COUNT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

### rtl/bisect_order_generator.sv
// Next: accepted, then the counter codes are tried in turn (one or two in practice),
//   sharing one reverse/compare unit; stalls there while the output is full.
// Restart: accepted, then one restoring division step per index bit, then the
//   counter is loaded.
// One item at a time; a waiting result does not block acceptance of the next item.
// Reset (rst_ni low, asynchronous): counter cleared, limit set to 65536, output empty.
module bisect_order_generator #(
  parameter int INDEX_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [bog_pkg::OFFSET_W-1:0]  start_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bog_pkg::VALUE_W-1:0]   index_value_o
);
  import bog_pkg::*;

  localparam int CW = INDEX_BITS;
  localparam int NW = (INDEX_BITS < LIMIT_W) ? INDEX_BITS : LIMIT_W;
  localparam int DW = LIMIT_W + 1;
  localparam int TopLimInt = (INDEX_BITS >= LIMIT_W) ? ((1 << LIMIT_W) - 1)
                                                     : (1 << INDEX_BITS);
  localparam logic [LIMIT_W-1:0] TopLim = TopLimInt[LIMIT_W-1:0];
  localparam logic [LIMIT_W-1:0] EffReset = (LIMIT_RESET > TopLim) ? TopLim : LIMIT_RESET;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NEXT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [LIMIT_W-1:0]  limit_q, eff_lim_q;
  logic [COUNT_W-1:0]  nbits_q;
  logic [CW-1:0]       counter_q, counter_d;
  logic [LIMIT_W-1:0]  rem_q, rem_d;
  logic [NW-1:0]       quot_q, quot_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  value_q, value_d;

  logic                cfg_we;
  logic [LIMIT_W-1:0]  wr_lim;
  logic                in_accept;
  logic                out_free;
  logic [CW-1:0]       cmask, cur, cur_inc;
  logic [NW-1:0]       rev_full, rev;
  logic [COUNT_W-1:0]  shamt;
  logic [DW-1:0]       lim_ext, rem2, cmp_a;
  logic                ge;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_INDEX_LIMIT);
  assign wr_lim = eff_limit(pwdata[LIMIT_W-1:0], TopLim);
  assign prdata = (paddr[2] == REG_INDEX_LIMIT) ? 32'(limit_q) : 32'd0;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign index_value_o = value_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // shared reverse and compare unit
  assign cmask   = (CW'(1) << nbits_q) - CW'(1);
  assign cur     = counter_q & cmask;
  assign cur_inc = (cur + CW'(1)) & cmask;
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      rev_full[i] = cur[NW-1-i];
    end
  end
  assign shamt   = COUNT_W'(NW) - nbits_q;
  assign rev     = rev_full >> shamt;
  assign lim_ext = {1'b0, eff_lim_q};
  assign rem2    = {rem_q, 1'b0};

  always_comb begin
    unique case (state_q)
      ST_NEXT: cmp_a = DW'(rev);
      ST_DIV:  cmp_a = rem2;
      default: cmp_a = DW'(start_offset_i);
    endcase
  end
  assign ge = (cmp_a >= lim_ext);

  always_comb begin
    state_d     = state_q;
    counter_d   = counter_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_NEXT: begin
        if (ge) begin
          counter_d = cur_inc;
        end else if (out_free) begin
          counter_d   = cur_inc;
          value_d     = VALUE_W'(rev);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          counter_d = CW'(quot_q);
          state_d   = ST_IDLE;
        end else begin
          rem_d  = LIMIT_W'(ge ? (rem2 - lim_ext) : rem2);
          quot_d = NW'({quot_q, ge});
          cnt_d  = cnt_q - COUNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        if (in_accept) begin
          if (command_i == CMD_RESTART) begin
            rem_d   = ge ? (eff_lim_q - LIMIT_W'(1)) : LIMIT_W'(start_offset_i);
            quot_d  = '0;
            cnt_d   = nbits_q;
            state_d = ST_DIV;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
      eff_lim_q   <= EffReset;
      nbits_q     <= bits_for(EffReset - LIMIT_W'(1));
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we) begin
        limit_q   <= pwdata[LIMIT_W-1:0];
        eff_lim_q <= wr_lim;
        nbits_q   <= bits_for(wr_lim - LIMIT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    value_q <= value_d;
  end

  a_value_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, index_value_o} < {1'b0, eff_lim_q}))
    else $error("index beyond limit");

  a_rem_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((rem_q < eff_lim_q) && (cnt_q <= nbits_q)))
    else $error("division state out of range");

  a_next_enters_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (command_i == CMD_NEXT)) |=> (state_q == ST_NEXT))
    else $error("next beat did not start search");

  a_restart_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("restart produced a result");

endmodule
